// ===== rtl/core/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, event codes and register indexes of the button event detector.
// ----------------------------------------------------------------------------
package bed_pkg;

	localparam int TICK_WIDTH_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam int EVENT_W    = 3;
	localparam int PCOUNT_W   = 8;
	localparam int THRESH_W   = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_MULTI   = 3'd2;
	localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd3;
	localparam logic [EVENT_W-1:0] EV_LONG    = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DETECT_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MULTI_INTERVAL   = 2'd3;

	localparam logic [THRESH_W-1:0] DETECT_THRESHOLD_RST = 16'd2;
	localparam logic [THRESH_W-1:0] HOLD_THRESHOLD_RST   = 16'd100;
	localparam logic [THRESH_W-1:0] MULTI_INTERVAL_RST   = 16'd0;

	typedef struct packed {
		logic                active_level;
		logic [THRESH_W-1:0] detect_threshold;
		logic [THRESH_W-1:0] hold_threshold;
		logic [THRESH_W-1:0] multi_interval;
	} bed_cfg_t;

	typedef struct packed {
		logic [EVENT_W-1:0]  event_code;
		logic [PCOUNT_W-1:0] press_count;
		logic                is_pressed;
	} bed_result_t;

endpackage

// ===== rtl/core/bed_ifs.sv =====
// ----------------------------------------------------------------------------
// bed channel interfaces
// Valid/ready channels for pin samples, detector results and register writes.
// ----------------------------------------------------------------------------
interface bed_pin_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink   (input valid, input pin_level, output ready);
endinterface

interface bed_result_if;
	import bed_pkg::*;
	logic                valid;
	logic                ready;
	logic [EVENT_W-1:0]  event_code;
	logic [PCOUNT_W-1:0] press_count;
	logic                is_pressed;

	modport source (output valid, output event_code, output press_count, output is_pressed,
		input ready);
	modport sink   (input valid, input event_code, input press_count, input is_pressed,
		output ready);
endinterface

interface bed_cfg_if;
	import bed_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bed_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bed_cfg_regs
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
module bed_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	bed_cfg_if.sink          cfg,
	output bed_pkg::bed_cfg_t cfg_q
);
	import bed_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= 1'b0;
			cfg_q.detect_threshold <= DETECT_THRESHOLD_RST;
			cfg_q.hold_threshold   <= HOLD_THRESHOLD_RST;
			cfg_q.multi_interval   <= MULTI_INTERVAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ACTIVE_LEVEL:     cfg_q.active_level     <= cfg.data[0];
				REG_DETECT_THRESHOLD: cfg_q.detect_threshold <= cfg.data[THRESH_W-1:0];
				REG_HOLD_THRESHOLD:   cfg_q.hold_threshold   <= cfg.data[THRESH_W-1:0];
				REG_MULTI_INTERVAL:   cfg_q.multi_interval   <= cfg.data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/bed_engine.sv =====
// ----------------------------------------------------------------------------
// bed_engine
// Debounce, multi-press window and hold counters; one tick per step.
// ----------------------------------------------------------------------------
module bed_engine #(
	parameter int TICK_WIDTH  = bed_pkg::TICK_WIDTH_DEF,
	parameter int COUNT_WIDTH = bed_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                pin_level,
	input  bed_pkg::bed_cfg_t   cfg,
	output bed_pkg::bed_result_t result
);
	import bed_pkg::*;

	localparam int CMP_W = (TICK_WIDTH > THRESH_W) ? TICK_WIDTH : THRESH_W;
	localparam int PC_W  = (COUNT_WIDTH > PCOUNT_W) ? COUNT_WIDTH : PCOUNT_W;

	logic                   pressed_q;
	logic [TICK_WIDTH-1:0]  level_ticks_q;
	logic [COUNT_WIDTH-1:0] multi_count_q;
	logic [TICK_WIDTH-1:0]  window_ticks_q;

	logic                   pressed_n;
	logic [TICK_WIDTH-1:0]  level_ticks_n;
	logic [COUNT_WIDTH-1:0] multi_count_n;
	logic [TICK_WIDTH-1:0]  window_ticks_n;
	logic [EVENT_W-1:0]     event_n;

	logic                   at_active;
	logic [TICK_WIDTH-1:0]  level_ticks_inc;
	logic [TICK_WIDTH-1:0]  window_ticks_inc;
	logic [PC_W-1:0]        count_wide;

	assign at_active        = (pin_level == cfg.active_level);
	assign level_ticks_inc  = (&level_ticks_q) ? level_ticks_q
		: level_ticks_q + TICK_WIDTH'(1);
	assign window_ticks_inc = (&window_ticks_q) ? window_ticks_q
		: window_ticks_q + TICK_WIDTH'(1);

	always_comb begin
		pressed_n      = pressed_q;
		level_ticks_n  = level_ticks_q;
		multi_count_n  = multi_count_q;
		window_ticks_n = window_ticks_q;
		event_n        = EV_NONE;

		// multi-press window ages first
		if (multi_count_q != '0) begin
			if (CMP_W'(window_ticks_inc) > CMP_W'(cfg.multi_interval)) begin
				multi_count_n  = '0;
				window_ticks_n = '0;
			end else begin
				window_ticks_n = window_ticks_inc;
			end
		end

		if (!pressed_q) begin
			if (at_active) begin
				if (CMP_W'(level_ticks_q) >= CMP_W'(cfg.detect_threshold)) begin
					pressed_n      = 1'b1;
					level_ticks_n  = TICK_WIDTH'(1);
					multi_count_n  = (&multi_count_n) ? multi_count_n
						: multi_count_n + COUNT_WIDTH'(1);
					window_ticks_n = '0;
					event_n        = (multi_count_n > COUNT_WIDTH'(1)) ? EV_MULTI : EV_PRESS;
				end else begin
					level_ticks_n = level_ticks_inc;
				end
			end
		end else begin
			if (!at_active) begin
				pressed_n     = 1'b0;
				level_ticks_n = '0;
				event_n       = EV_RELEASE;
			end else begin
				level_ticks_n = level_ticks_inc;
				if (!(&level_ticks_q)
					&& (CMP_W'(level_ticks_inc) == CMP_W'(cfg.hold_threshold))) begin
					event_n = EV_LONG;
				end
			end
		end
	end

	assign count_wide = PC_W'(multi_count_n);

	always_comb begin
		result.event_code  = event_n;
		result.press_count = (count_wide > PC_W'(255)) ? 8'hFF : count_wide[PCOUNT_W-1:0];
		result.is_pressed  = pressed_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q      <= 1'b0;
			level_ticks_q  <= '0;
			multi_count_q  <= '0;
			window_ticks_q <= '0;
		end else if (step) begin
			pressed_q      <= pressed_n;
			level_ticks_q  <= level_ticks_n;
			multi_count_q  <= multi_count_n;
			window_ticks_q <= window_ticks_n;
		end
	end

endmodule

// ===== rtl/core/button_event_detector.sv =====
// ----------------------------------------------------------------------------
// button_event_detector
// Button debounce with press, multi-press, release and long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   pin    : one transaction per tick, carrying the sampled button level
//   result : exactly one transaction per pin transaction, in order, with the
//            event code, the multi-press count and the pressed flag
//   cfg    : register writes (active level, detect threshold, hold threshold,
//            multi-press interval); always ready; the user must write only while idle (not enforced)
// From pin acceptance to result valid, a tick passes the input register, then
// the counter update and the result register. Throughput is one tick per
// cycle unless the receiver stalls; the counter state is a single register
// stage updated in the cycle a tick moves into the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and pin ready drops until the result is taken.
// Reset clears all counters, the pressed flag and both pipeline valids, and
// loads the register defaults.
// ----------------------------------------------------------------------------
module button_event_detector #(
	parameter int TICK_WIDTH  = bed_pkg::TICK_WIDTH_DEF,
	parameter int COUNT_WIDTH = bed_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bed_pin_if.sink       pin,
	bed_result_if.source  result,
	bed_cfg_if.sink       cfg
);
	import bed_pkg::*;

	bed_cfg_t    cfg_q;
	bed_result_t engine_result;
	bed_result_t result_s2;
	logic        valid_s1;
	logic        pin_level_s1;
	logic        valid_s2;
	logic        out_free;
	logic        advance;

	assign out_free  = !valid_s2 || result.ready;
	assign advance   = valid_s1 && out_free;
	assign pin.ready = !valid_s1 || out_free;

	bed_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	bed_engine #(
		.TICK_WIDTH  (TICK_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_level_s1),
		.cfg       (cfg_q),
		.result    (engine_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pin.valid && pin.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pin.valid && pin.ready) begin
			pin_level_s1 <= pin.pin_level;
		end
		if (advance) begin
			result_s2 <= engine_result;
		end
	end

	assign result.valid       = valid_s2;
	assign result.event_code  = result_s2.event_code;
	assign result.press_count = result_s2.press_count;
	assign result.is_pressed  = result_s2.is_pressed;

endmodule

// ===== test/bed_event_checker.sv =====
// ----------------------------------------------------------------------------
// bed_event_checker
// Watches the pin, result and register channels of the button event detector.
// It keeps its own debounce, multi-press and long-press state and predicts
// one result per accepted pin transaction. Each accepted result is compared
// field by field with the oldest prediction. It reports the mismatch count
// and the number of results still outstanding.
// ----------------------------------------------------------------------------
module bed_event_checker (
	input  logic  clk,
	input  logic  arst_n,
	bed_pin_if    pin,
	bed_result_if result,
	bed_cfg_if    cfg,
	output int    mismatch_count,
	output int    events_outstanding
);
	import bed_pkg::*;

	localparam logic [15:0] TICK_MAX  = '1;
	localparam logic [7:0]  COUNT_MAX = '1;

	logic        active_level;
	logic [15:0] detect_thr;
	logic [15:0] hold_thr;
	logic [15:0] multi_int;

	logic        pressed;
	logic [15:0] level_ticks;
	logic [15:0] window_ticks;
	logic [7:0]  press_cnt;

	bed_result_t expected_events[$];

	function automatic bed_result_t predict_tick(input logic lvl);
		bed_result_t r;
		logic        at_active;
		logic        stepped;
		r.event_code = EV_NONE;
		at_active = (lvl == active_level);
		// multi-press window ages before anything else
		if (press_cnt != 0) begin
			if (window_ticks != TICK_MAX)
				window_ticks = window_ticks + 1'b1;
			if (window_ticks > multi_int) begin
				press_cnt = '0;
				window_ticks = '0;
			end
		end
		if (!pressed) begin
			if (at_active) begin
				if (level_ticks >= detect_thr) begin
					pressed = 1'b1;
					level_ticks = '0;
					if (press_cnt != COUNT_MAX)
						press_cnt = press_cnt + 1'b1;
					window_ticks = '0;
					r.event_code = (press_cnt > 1) ? EV_MULTI : EV_PRESS;
				end
				if (level_ticks != TICK_MAX)
					level_ticks = level_ticks + 1'b1;
			end
		end else begin
			stepped = (level_ticks != TICK_MAX);
			if (stepped)
				level_ticks = level_ticks + 1'b1;
			if (!at_active) begin
				pressed = 1'b0;
				level_ticks = '0;
				r.event_code = EV_RELEASE;
			end else if (stepped && level_ticks == hold_thr) begin
				r.event_code = EV_LONG;
			end
		end
		r.press_count = press_cnt;
		r.is_pressed = pressed;
		return r;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bed_result_t want;
		if (!arst_n) begin
			active_level = 1'b0;
			detect_thr = DETECT_THRESHOLD_RST;
			hold_thr = HOLD_THRESHOLD_RST;
			multi_int = MULTI_INTERVAL_RST;
			pressed = 1'b0;
			level_ticks = '0;
			window_ticks = '0;
			press_cnt = '0;
			expected_events.delete();
			mismatch_count = 0;
			events_outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ACTIVE_LEVEL:     active_level = cfg.data[0];
					REG_DETECT_THRESHOLD: detect_thr = cfg.data;
					REG_HOLD_THRESHOLD:   hold_thr = cfg.data;
					REG_MULTI_INTERVAL:   multi_int = cfg.data;
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_events.size() == 0) begin
					mismatch_count++;
					$display("%0t unexpected result transaction: expected none actual event %0d",
						$time, result.event_code);
				end else begin
					want = expected_events.pop_front();
					check_field("event_code", int'(want.event_code), int'(result.event_code));
					check_field("press_count", int'(want.press_count),
						int'(result.press_count));
					check_field("is_pressed", int'(want.is_pressed), int'(result.is_pressed));
				end
			end
			if (pin.valid && pin.ready)
				expected_events.push_back(predict_tick(pin.pin_level));
			events_outstanding <= expected_events.size();
		end
	end

endmodule

// ===== test/tb_button_event_detector.sv =====
// ----------------------------------------------------------------------------
// tb_button_event_detector
// Stimulus and verdict for the button event detector. A short directed run
// covers press, multi-press, release, long press, bounces and release on the
// hold tick. Random press and release patterns follow under many register
// settings with sender and receiver stalls, then a long run of presses that
// saturates the press count, and a run with an unreachable hold and zero window.
// ----------------------------------------------------------------------------
module tb_button_event_detector;
	import bed_pkg::*;

	localparam int          CHUNK_ITEMS   = 12;
	localparam logic [14:0] DIRECTED_SEQ  = 15'b111110_101_10_1110;

	logic clk;
	logic arst_n;
	int   src_idle  = 0;
	int   sink_idle = 0;
	int   mismatch_count;
	int   events_outstanding;

	bed_pin_if    pin_ch();
	bed_result_if res_ch();
	bed_cfg_if    cfg_ch();

	button_event_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pin    (pin_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	bed_event_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.pin                (pin_ch),
		.result             (res_ch),
		.cfg                (cfg_ch),
		.mismatch_count     (mismatch_count),
		.events_outstanding (events_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 3000000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
		end
	end

	task automatic send_tick(input logic lvl);
		while ($urandom_range(0, 99) < src_idle) begin
			pin_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pin_ch.valid <= 1'b1;
		pin_ch.pin_level <= lvl;
		do @(posedge clk); while (!pin_ch.ready);
	endtask

	task automatic drain_results;
		pin_ch.valid <= 1'b0;
		do @(posedge clk); while (events_outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_config(input logic act, input logic [15:0] det,
		input logic [15:0] hold, input logic [15:0] intv);
		write_reg(REG_ACTIVE_LEVEL, {15'd0, act});
		write_reg(REG_DETECT_THRESHOLD, det);
		write_reg(REG_HOLD_THRESHOLD, hold);
		write_reg(REG_MULTI_INTERVAL, intv);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_threshold(input int small_max);
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, small_max));
		endcase
	endfunction

	// press runs with random length and a release run, mixed with single noise ticks
	task automatic run_presses(input int n_items, input logic act);
		int sent;
		int held;
		int gap;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				send_tick(1'($urandom_range(0, 1)));
				sent++;
			end else begin
				held = $urandom_range(1, 24);
				gap = $urandom_range(1, 6);
				repeat (held) send_tick(act);
				repeat (gap) send_tick(!act);
				sent += held + gap;
			end
		end
	endtask

	initial begin
		logic act;
		arst_n <= 1'b0;
		pin_ch.valid <= 1'b0;
		pin_ch.pin_level <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_ACTIVE_LEVEL;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: active low, detect after two ticks
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		send_tick(1'b1);
		drain_results();

		// long press, bounce, multi-press, release on the hold tick
		set_config(1'b1, 16'd1, 16'd3, 16'd10);
		for (int i = 14; i >= 0; i--)
			send_tick(DIRECTED_SEQ[i]);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 7 : (phase == 1) ? 49 : 0;
			sink_idle = (phase == 0) ? 49 : (phase == 1) ? 7 : 0;
			repeat (5) begin
				drain_results();
				act = 1'($urandom_range(0, 1));
				set_config(act, pick_threshold(5), pick_threshold(20), pick_threshold(12));
				run_presses(CHUNK_ITEMS, act);
			end
		end

		// press count saturation
		drain_results();
		set_config(1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
		repeat (258) begin
			send_tick(1'b0);
			send_tick(1'b1);
		end

		// unreachable hold, zero window
		drain_results();
		set_config(1'b0, 16'd0, 16'd0, 16'd0);
		run_presses(40, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
